// ----- hw/rtl/pttt_pkg.sv -----
// Package for the periodic task timer table: widths, codes and the structs
// that travel between the top level and its channel cells.
// No dependencies.
`default_nettype none

package pttt_pkg;

  // Default number of channels in the table.
  localparam int NUM_CHANNELS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int ChanW = 3;
  localparam int TimeW = 32;
  localparam int FuncW = 2;
  localparam int MaskW = 8;

  // Operation codes on func_i.
  localparam logic [FuncW-1:0] FuncTick   = 2'd0;
  localparam logic [FuncW-1:0] FuncSetEn  = 2'd1;
  localparam logic [FuncW-1:0] FuncSetPer = 2'd2;

  // Event kinds reported on event_kind_o.
  typedef enum logic [1:0] {
    KindFire     = 2'd0,
    KindFirst    = 2'd1,
    KindEnabled  = 2'd2,
    KindDisabled = 2'd3
  } event_kind_e;

  // Walk token and tick time handed from one cell to the next.
  typedef struct packed {
    logic             tok;
    logic [TimeW-1:0] now;
  } link_t;

  // Table write command addressed to one cell.
  typedef struct packed {
    logic             en_wr;
    logic             en_val;
    logic             per_wr;
    logic [TimeW-1:0] per_val;
  } cmd_t;

  // Event raised by a cell while it holds the walk token.
  typedef struct packed {
    logic             valid;
    event_kind_e      kind;
    logic [TimeW-1:0] elapsed;
  } ev_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pttt_cell.sv -----
// One channel cell of the timer table: period, due time, enable and started
// state, plus the walk-token stage of the chain. Depends on pttt_pkg.
`default_nettype none

module pttt_cell
  import pttt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  present_i,
  input  link_t link_i,
  output link_t link_o,
  input  cmd_t  cmd_i,
  output logic  enable_o,
  output ev_t   ev_o
);

  link_t            link_q;
  logic [TimeW-1:0] period_q, period_d;
  logic [TimeW-1:0] due_q, due_d;
  logic             enable_q, enable_d;
  logic             started_q, started_d;
  logic             eval;

  // Token stage: the walk visits this cell for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_i;
    end
  end

  assign link_o   = link_q;
  assign enable_o = enable_q;
  assign eval     = link_q.tok & present_i;

  // Channel evaluation and table writes.
  always_comb begin
    period_d    = period_q;
    due_d       = due_q;
    enable_d    = enable_q;
    started_d   = started_q;
    ev_o        = '0;
    ev_o.kind   = KindFire;
    if (cmd_i.en_wr) begin
      enable_d = cmd_i.en_val;
    end
    if (cmd_i.per_wr) begin
      period_d = cmd_i.per_val;
    end
    if (eval) begin
      if (!started_q) begin
        ev_o.valid = 1'b1;
        ev_o.kind  = KindFirst;
        started_d  = 1'b1;
        due_d      = link_q.now + period_q;
      end else if (period_q != '0) begin
        if ((link_q.now >= due_q) && enable_q) begin
          ev_o.valid   = 1'b1;
          ev_o.elapsed = link_q.now - due_q + period_q;
          due_d        = link_q.now + period_q;
        end
      end else begin
        ev_o.valid   = 1'b1;
        ev_o.elapsed = link_q.now - due_q;
        due_d        = link_q.now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      due_q     <= '0;
      enable_q  <= 1'b1;
      started_q <= 1'b0;
    end else begin
      period_q  <= period_d;
      due_q     <= due_d;
      enable_q  <= enable_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_task_timer_table_core.sv -----
// Periodic task timer table top level: command port, chain of channel cells,
// one-deep event hold and registered result ports. Depends on pttt_pkg, pttt_cell.
//
// A tick is walked one cell per cycle through min(NumChannels, 8) cells, then a
// flush cycle; busy is high while the token is in a cell and during the flush cycle,
// and no transaction is taken while busy is high.
// Each event is held until the next one is raised or the flush cycle comes and shows
// in the cycle after that; the last one shows in the cycle after the flush. Set-enable
// and set-period never raise busy, and an enable event shows the next cycle.
// The receiver cannot stall. Reset restores the table at once: no clearing pass.
`default_nettype none

module periodic_task_timer_table_core
  import pttt_pkg::*;
#(
  parameter int NumChannels = NUM_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [FuncW-1:0] func_i,
  input  logic [ChanW-1:0] channel_sel_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             enable_value_i,
  input  logic [TimeW-1:0] period_value_i,
  input  logic             cfg_we_i,
  input  logic [MaskW-1:0] cfg_wdata_i,
  output logic             event_valid_o,
  output logic [ChanW-1:0] event_channel_o,
  output logic [1:0]       event_kind_o,
  output logic [TimeW-1:0] elapsed_ms_o,
  output logic             last_o
);

  localparam int CellCount = (NumChannels < 8) ? NumChannels : 8;

  logic [MaskW-1:0]     present_q;
  link_t                link [CellCount+1];
  cmd_t                 cmd  [CellCount];
  ev_t                  ev   [CellCount];
  logic [CellCount-1:0] en_vec;
  logic [CellCount-1:0] tok_vec;
  logic                 accept, sel_ok, old_en, set_en_ev;
  logic                 flush_q;
  ev_t                  ev_any;
  logic [ChanW-1:0]     ev_ch;
  logic                 pend_valid_q, pend_valid_d;
  ev_t                  pend_q;
  logic [ChanW-1:0]     pend_ch_q;
  logic                 out_load, out_valid_q;
  logic [ChanW-1:0]     out_ch_d, out_ch_q;
  event_kind_e          out_kind_d, out_kind_q;
  logic [TimeW-1:0]     out_el_d, out_el_q;
  logic                 out_last_d, out_last_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cfg_we_i) begin
      present_q <= cfg_wdata_i;
    end
  end

  assign accept   = start & ~busy;
  assign sel_ok   = 32'(channel_sel_i) < NumChannels;
  assign link[0]  = '{tok: accept && (func_i == FuncTick), now: now_ms_i};

  // Chain of channel cells.
  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    assign cmd[i].en_wr   = accept && (func_i == FuncSetEn) && sel_ok
                            && (channel_sel_i == ChanW'(i));
    assign cmd[i].en_val  = enable_value_i;
    assign cmd[i].per_wr  = accept && (func_i == FuncSetPer) && sel_ok
                            && (channel_sel_i == ChanW'(i));
    assign cmd[i].per_val = period_value_i;
    assign tok_vec[i]     = link[i+1].tok;

    pttt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .present_i(present_q[i]),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .cmd_i    (cmd[i]),
      .enable_o (en_vec[i]),
      .ev_o     (ev[i])
    );
  end

  assign busy = (|tok_vec) | flush_q;

  // Old enable bit of the addressed channel and the enable change event.
  always_comb begin
    old_en = 1'b0;
    for (int i = 0; i < CellCount; i++) begin
      if (channel_sel_i == ChanW'(i)) begin
        old_en = en_vec[i];
      end
    end
  end

  assign set_en_ev = accept && (func_i == FuncSetEn) && sel_ok
                     && (old_en != enable_value_i);

  // Only the cell holding the token can raise an event.
  always_comb begin
    ev_any      = '0;
    ev_any.kind = KindFire;
    ev_ch       = '0;
    for (int i = 0; i < CellCount; i++) begin
      if (ev[i].valid) begin
        ev_any = ev[i];
        ev_ch  = ChanW'(i);
      end
    end
  end

  // Flush cycle follows the last cell of the walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= 1'b0;
    end else begin
      flush_q <= link[CellCount].tok;
    end
  end

  // Hold one event back so the final one of a walk can carry last.
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (ev_any.valid) begin
      pend_valid_d = 1'b1;
    end else if (flush_q) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_any.valid) begin
      pend_q    <= ev_any;
      pend_ch_q <= ev_ch;
    end
  end

  // Result register selection.
  always_comb begin
    out_load   = 1'b0;
    out_ch_d   = pend_ch_q;
    out_kind_d = pend_q.kind;
    out_el_d   = pend_q.elapsed;
    out_last_d = 1'b0;
    if (set_en_ev) begin
      out_load   = 1'b1;
      out_ch_d   = channel_sel_i;
      out_kind_d = enable_value_i ? KindEnabled : KindDisabled;
      out_el_d   = '0;
      out_last_d = 1'b1;
    end else if (ev_any.valid && pend_valid_q) begin
      out_load = 1'b1;
    end else if (flush_q && pend_valid_q) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= out_ch_d;
      out_kind_q <= out_kind_d;
      out_el_q   <= out_el_d;
      out_last_q <= out_last_d;
    end
  end

  assign event_valid_o   = out_valid_q;
  assign event_channel_o = out_ch_q;
  assign event_kind_o    = out_kind_q;
  assign elapsed_ms_o    = out_el_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pttt_checker.sv -----
// Port-level checker for the periodic task timer table, bound to the top
// level. Depends on pttt_pkg and periodic_task_timer_table_core.
`default_nettype none

module pttt_checker
  import pttt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [FuncW-1:0] func_i,
  input logic             event_valid_o,
  input logic [1:0]       event_kind_o,
  input logic [TimeW-1:0] elapsed_ms_o,
  input logic             last_o
);

  // A tick transaction starts a walk.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncTick) |=> busy)
    else $error("tick transaction did not raise busy");

  // Setting a period never produces an event.
  a_set_per_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncSetPer) |=> !event_valid_o)
    else $error("set period produced an event");

  // An enable change event is the only and final event of its transaction.
  a_set_en_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncSetEn) |=> (!event_valid_o || last_o))
    else $error("set enable event without last");

  // Enable and disable events carry no elapsed time.
  a_en_kind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && (event_kind_o == KindEnabled || event_kind_o == KindDisabled))
    |-> (last_o && elapsed_ms_o == '0))
    else $error("enable event with elapsed time or without last");

endmodule

bind periodic_task_timer_table_core pttt_checker u_pttt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .func_i       (func_i),
  .event_valid_o(event_valid_o),
  .event_kind_o (event_kind_o),
  .elapsed_ms_o (elapsed_ms_o),
  .last_o       (last_o)
);

`default_nettype wire
